// ===== rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the byte stack with palindrome check:
// command and status codes, the input and result beat structs, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // Built depth of the stack store and derived widths
    localparam int MAX_DEPTH = 16;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = 5;
    localparam int BYTE_W    = 8;

    // Capacity register after reset
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    // Fixed bytes returned on failure or when no byte is read
    localparam logic [BYTE_W-1:0] FAIL_POP_BYTE  = 8'h20;
    localparam logic [BYTE_W-1:0] FAIL_PEEK_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE      = 8'h00;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CHECK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       push_byte;
        logic [CNT_W-1:0] peek_position;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic [1:0]       status;
        logic             is_palindrome;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic             is_full;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic walk;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic out_free;
    } dp_status_t;

    // Effective capacity: zero acts as one, anything above the depth as the depth
    function automatic logic [CNT_W-1:0] live_capacity(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] c;
        c = cap;
        if (c == '0)
        begin
            c = CNT_W'(1);
        end
        else if (c > CNT_W'(MAX_DEPTH))
        begin
            c = CNT_W'(MAX_DEPTH);
        end
        return c;
    endfunction

endpackage

// ===== rtl/bsp_ram.sv =====
// ----------------------------------------------------------------------------
// bsp_ram
// Generic RAM: one write port, two read ports with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsp_ctrl
// Controller for the byte stack: takes one beat, runs the command step,
// walks a check of two or more bytes, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsp_pkg::dp_status_t dp_status,
    output bsp_pkg::dp_cmd_t    dp_cmd
);

    import bsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = dp_status.need_walk ? S_WALK : S_EMIT;
            end
            S_WALK:
            begin
                if (dp_status.walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        dp_cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                dp_cmd.execute = 1'b1;
            end
            S_WALK:
            begin
                dp_cmd.walk = 1'b1;
            end
            S_EMIT:
            begin
                dp_cmd.emit = dp_status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/bsp_datapath.sv =====
// ----------------------------------------------------------------------------
// bsp_datapath
// Stack store, fill count, capacity register, palindrome walk pointers and
// the result register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module bsp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsp_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bsp_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [bsp_pkg::CNT_W-1:0]         cfg_data,
    input  bsp_pkg::dp_cmd_t                  dp_cmd,
    output bsp_pkg::dp_status_t               dp_status
);

    import bsp_pkg::*;

    // Control state
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic              out_valid_reg;

    // Payload state
    cmd_t              cmd_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] lo_reg,     lo_next;
    logic [ADDR_W-1:0] hi_reg,     hi_next;
    logic              pal_reg,    pal_next;
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] fixed_reg,  fixed_next;
    logic              use_ram_reg, use_ram_next;
    out_item_t         out_reg;

    // Memory interface
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [BYTE_W-1:0] rd_data_a;
    logic [BYTE_W-1:0] rd_data_b;

    logic              is_full;
    logic              mismatch;
    logic              last_pair;
    logic [CNT_W-1:0]  peek_index;

    assign is_full    = (count_reg >= live_capacity(cap_reg));
    assign mismatch   = (rd_data_a != rd_data_b);
    assign last_pair  = ((hi_reg - lo_reg) <= ADDR_W'(2));
    assign peek_index = count_reg - pos_reg;

    bsp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .clk       (clk),
        .we        (ram_we),
        .wr_addr   (count_reg[ADDR_W-1:0]),
        .wr_data   (byte_reg),
        .re        (ram_re),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Command step and palindrome walk
    always_comb
    begin
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pal_next     = pal_reg;
        status_next  = status_reg;
        fixed_next   = fixed_reg;
        use_ram_next = use_ram_reg;
        ram_we       = 1'b0;
        ram_re       = dp_cmd.execute || dp_cmd.walk;
        rd_addr_a    = lo_reg;
        rd_addr_b    = hi_reg;

        if (dp_cmd.execute)
        begin
            pal_next     = 1'b0;
            status_next  = ST_OK;
            fixed_next   = ZERO_BYTE;
            use_ram_next = 1'b0;
            unique case (cmd_reg)
                CMD_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                        fixed_next  = FAIL_POP_BYTE;
                    end
                    else
                    begin
                        count_next   = count_reg - CNT_W'(1);
                        rd_addr_a    = count_next[ADDR_W-1:0];
                        use_ram_next = 1'b1;
                    end
                end
                CMD_PEEK:
                begin
                    if (pos_reg == '0 || pos_reg > count_reg)
                    begin
                        status_next = ST_INVALID;
                        fixed_next  = FAIL_PEEK_BYTE;
                    end
                    else
                    begin
                        rd_addr_a    = peek_index[ADDR_W-1:0];
                        use_ram_next = 1'b1;
                    end
                end
                CMD_CHECK:
                begin
                    // Fewer than two bytes reads the same both ways
                    pal_next  = (count_reg < CNT_W'(2));
                    lo_next   = '0;
                    hi_next   = ADDR_W'(count_reg - CNT_W'(1));
                    rd_addr_a = lo_next;
                    rd_addr_b = hi_next;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (dp_cmd.walk)
        begin
            // Compare one pair from both ends, then step inwards
            if (mismatch)
            begin
                pal_next = 1'b0;
            end
            else if (last_pair)
            begin
                pal_next = 1'b1;
            end
            else
            begin
                lo_next   = lo_reg + ADDR_W'(1);
                hi_next   = hi_reg - ADDR_W'(1);
                rd_addr_a = lo_next;
                rd_addr_b = hi_next;
            end
        end
    end

    assign dp_status.need_walk = (cmd_reg == CMD_CHECK) && (count_reg >= CNT_W'(2));
    assign dp_status.walk_done = mismatch || last_pair;
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (dp_cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd_t'(in_item.command);
            byte_reg <= in_item.push_byte;
            pos_reg  <= in_item.peek_position;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pal_reg     <= pal_next;
        status_reg  <= status_next;
        fixed_reg   <= fixed_next;
        use_ram_reg <= use_ram_next;
        if (dp_cmd.emit)
        begin
            out_reg.read_byte     <= use_ram_reg ? rd_data_a : fixed_reg;
            out_reg.status        <= status_reg;
            out_reg.is_palindrome <= pal_reg;
            out_reg.entry_count   <= count_reg;
            out_reg.is_empty      <= (count_reg == '0);
            out_reg.is_full       <= is_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DEPTH))
        else $error("fill count above built depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance fill count");

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.walk |-> lo_reg < hi_reg)
        else $error("walk pointers crossed");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while still held");

endmodule

// ===== rtl/byte_stack_palindrome_check.sv =====
// ----------------------------------------------------------------------------
// byte_stack_palindrome_check
// Byte-wide LIFO stack with push, pop, peek and palindrome check commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one command beat:
//   command, push byte and peek position. Each beat gives exactly one result
//   beat on the output channel (out_valid/out_ready/out_item) with the byte
//   read, status, palindrome flag, count, empty and full.
//   Push, pop and peek go from acceptance to result valid through the
//   execute step (with registered store read), then the result register; a
//   new beat is taken only after the result has been loaded.
//   Palindrome check for two or more bytes adds a walk step per compared
//   pair, at most count/2 pairs; one item is in flight at a time and the
//   next beat is taken once the result is loaded.
//   The walk is bound by the two-port read of the stack store, one pair
//   of ends per cycle.
//   The capacity register (cfg_we/cfg_data) is written in any cycle; write it
//   only when no command is in flight. Reset empties the stack and sets the
//   capacity to 16. When the receiver stalls the result holds in the output
//   register; a new command may be taken meanwhile, and its result waits
//   until the held beat has been taken.
// ----------------------------------------------------------------------------
module byte_stack_palindrome_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bsp_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bsp_pkg::out_item_t        out_item,
    input  logic                      cfg_we,
    input  logic [bsp_pkg::CNT_W-1:0] cfg_data
);

    import bsp_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    bsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

endmodule
